// File: sv/rsd_pkg.sv
// Shared types and constants of the RAID 0+1 stripe decomposer.
package rsd_pkg;

  localparam int ADDR_W   = 48;
  localparam int LEN_W    = 32;
  localparam int SU_W     = 25;
  localparam int CNT_W    = 6;
  localparam int DEV_W    = 8;
  localparam int CFG_N_W  = 5;
  localparam int SPAN_W   = ADDR_W + 1;
  localparam int DIV_STEPS = SPAN_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;

  localparam logic [SU_W-1:0] SU_MAX = 25'd16777216;

  localparam logic [1:0] KIND_DEV_READ     = 2'd0;
  localparam logic [1:0] KIND_DEV_WRITE    = 2'd1;
  localparam logic [1:0] KIND_READ_PARENT  = 2'd2;
  localparam logic [1:0] KIND_WRITE_PARENT = 2'd3;

  localparam logic [1:0] REG_DEVICES     = 2'd0;
  localparam logic [1:0] REG_STRIPE_UNIT = 2'd1;
  localparam logic [1:0] REG_DEVICE_BASE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_UNIT,
    ST_SPAN,
    ST_EMIT,
    ST_MIRROR,
    ST_PARENT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic unit_step;
    logic span;
    logic idx_next;
    logic emit_child;
    logic mirror;
    logic emit_parent;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic is_write;
    logic span_ok;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/rsd_regs.sv
// APB configuration registers of the stripe decomposer.
module rsd_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsd_pkg::APB_AW-1:0] paddr,
  input  logic [rsd_pkg::APB_DW-1:0] pwdata,
  output logic [rsd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [rsd_pkg::CFG_N_W-1:0] cfg_devices,
  output logic [rsd_pkg::SU_W-1:0]    cfg_stripe_unit,
  output logic [rsd_pkg::DEV_W-1:0]   cfg_device_base
);
  import rsd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_devices     <= CFG_N_W'(2);
      cfg_stripe_unit <= SU_W'(4096);
      cfg_device_base <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEVICES:     cfg_devices     <= pwdata[CFG_N_W-1:0];
        REG_STRIPE_UNIT: cfg_stripe_unit <= pwdata[SU_W-1:0];
        REG_DEVICE_BASE: cfg_device_base <= pwdata[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEVICES:     prdata = APB_DW'(cfg_devices);
      REG_STRIPE_UNIT: prdata = APB_DW'(cfg_stripe_unit);
      REG_DEVICE_BASE: prdata = APB_DW'(cfg_device_base);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: sv/rsd_ctrl.sv
// Sequencing state machine of the stripe decomposer.
module rsd_ctrl #(
  parameter int MAX_DEVICES_PER_SIDE = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rsd_pkg::status_t status,
  output rsd_pkg::cmd_t    cmd
);
  import rsd_pkg::*;

  localparam int DW = $clog2(MAX_DEVICES_PER_SIDE + 1);

  state_t              state, state_next;
  logic [STEP_W-1:0]   step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        step_next  = '0;
        state_next = status.empty ? ST_PARENT : ST_DIV;
      end
      ST_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = ST_UNIT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_UNIT: begin
        if (step == STEP_W'(DW - 1)) begin
          step_next  = '0;
          state_next = ST_SPAN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SPAN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!status.span_ok) begin
          state_next = status.idx_last ? ST_PARENT : ST_SPAN;
        end else if (status.out_free) begin
          if (status.is_write) state_next = ST_MIRROR;
          else state_next = status.idx_last ? ST_PARENT : ST_SPAN;
        end
      end
      ST_MIRROR: begin
        if (status.out_free) state_next = status.idx_last ? ST_PARENT : ST_SPAN;
      end
      ST_PARENT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:  cmd.load      = in_valid;
      ST_SETUP: cmd.setup     = 1'b1;
      ST_DIV:   cmd.div_step  = 1'b1;
      ST_UNIT:  cmd.unit_step = 1'b1;
      ST_SPAN:  cmd.span      = 1'b1;
      ST_EMIT: begin
        if (!status.span_ok) begin
          cmd.idx_next = !status.idx_last;
        end else if (status.out_free) begin
          cmd.emit_child = 1'b1;
          cmd.idx_next   = !status.is_write && !status.idx_last;
        end
      end
      ST_MIRROR: begin
        if (status.out_free) begin
          cmd.emit_child = 1'b1;
          cmd.mirror     = 1'b1;
          cmd.idx_next   = !status.idx_last;
        end
      end
      ST_PARENT: cmd.emit_parent = status.out_free;
      default: ;
    endcase
  end

endmodule

// File: sv/rsd_dpath.sv
// Divider lanes, span arithmetic and result register of the stripe decomposer.
module rsd_dpath #(
  parameter int MAX_DEVICES_PER_SIDE = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rsd_pkg::ADDR_W-1:0]   volume_address,
  input  logic [rsd_pkg::LEN_W-1:0]    request_bytes,
  input  logic                         is_write,
  input  logic [rsd_pkg::CFG_N_W-1:0]  cfg_devices,
  input  logic [rsd_pkg::SU_W-1:0]     cfg_stripe_unit,
  input  logic [rsd_pkg::DEV_W-1:0]    cfg_device_base,
  input  rsd_pkg::cmd_t                cmd,
  output rsd_pkg::status_t             status,
  input  logic                         out_stall,
  output logic                         out_valid,
  output logic [1:0]                   kind,
  output logic [rsd_pkg::DEV_W-1:0]    device_index,
  output logic [rsd_pkg::ADDR_W-1:0]   device_address,
  output logic [rsd_pkg::LEN_W-1:0]    length_bytes,
  output logic [rsd_pkg::CNT_W-1:0]    child_count,
  output logic                         last
);
  import rsd_pkg::*;

  localparam int DW = $clog2(MAX_DEVICES_PER_SIDE + 1);
  localparam int SW = SU_W + DW;

  // request snapshot
  logic [DW-1:0]     n_eff;
  logic [SU_W-1:0]   su_eff;
  logic [DEV_W-1:0]  base;
  logic              wr;
  logic              empty;
  logic [SW-1:0]     stripe;

  // lane 0 works on the first byte, lane 1 on the last byte
  logic [SPAN_W-1:0] dvd  [2];
  logic [SW-1:0]     rem  [2];
  logic [SPAN_W-1:0] prod [2];
  logic [DW-1:0]     du   [2];
  logic [SW-1:0]     dsr;

  logic [SW:0]       trial     [2];
  logic              big_ge    [2];
  logic              unit_ge   [2];
  logic [SW-1:0]     big_rem   [2];

  logic [DW-1:0]     idx;
  logic [SPAN_W-1:0] s_reg, e_reg;
  logic [SPAN_W-1:0] add_s, add_e;
  logic [SPAN_W:0]   diff;
  logic              toggle;
  logic [CNT_W-1:0]  count;
  logic              copy_sel;
  logic [DEV_W-1:0]  child_dev;
  logic              out_free;

  logic [DW-1:0]     n_clamp;
  logic [SU_W-1:0]   su_clamp;

  always_comb begin
    if (cfg_devices == '0) n_clamp = DW'(1);
    else if (cfg_devices > CFG_N_W'(MAX_DEVICES_PER_SIDE))
      n_clamp = DW'(MAX_DEVICES_PER_SIDE);
    else n_clamp = DW'(cfg_devices);

    if (cfg_stripe_unit == '0) su_clamp = SU_W'(1);
    else if (cfg_stripe_unit > SU_MAX) su_clamp = SU_MAX;
    else su_clamp = cfg_stripe_unit;
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l]   = {rem[l], dvd[l][SPAN_W-1]};
      big_ge[l]  = trial[l] >= {1'b0, stripe};
      big_rem[l] = big_ge[l] ? SW'(trial[l] - {1'b0, stripe}) : SW'(trial[l]);
      unit_ge[l] = rem[l] >= dsr;
    end
  end

  // span edges of the current device
  always_comb begin
    if (idx < du[0]) add_s = SPAN_W'(su_eff);
    else if (idx == du[0]) add_s = SPAN_W'(rem[0]);
    else add_s = '0;

    if (idx < du[1]) add_e = SPAN_W'(su_eff);
    else if (idx == du[1]) add_e = SPAN_W'(rem[1]) + SPAN_W'(1);
    else add_e = '0;
  end

  assign diff      = {1'b0, e_reg} - {1'b0, s_reg};
  assign out_free  = !out_valid || !out_stall;
  assign copy_sel  = wr ? cmd.mirror : toggle;
  assign child_dev = base + DEV_W'(idx) + (copy_sel ? DEV_W'(n_eff) : DEV_W'(0));

  assign status.empty    = empty;
  assign status.is_write = wr;
  assign status.span_ok  = !diff[SPAN_W] && (diff != '0);
  assign status.idx_last = (idx == n_eff - 1'b1);
  assign status.out_free = out_free;

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_eff  <= n_clamp;
      su_eff <= su_clamp;
      base   <= cfg_device_base;
      wr     <= is_write;
      empty  <= (request_bytes == '0);
      dvd[0] <= SPAN_W'(volume_address);
      dvd[1] <= SPAN_W'(volume_address) + SPAN_W'(request_bytes) - SPAN_W'(1);
    end
    if (cmd.setup) begin
      stripe <= SW'({{SU_W{1'b0}}, n_eff} * {{DW{1'b0}}, su_eff});
      dsr    <= SW'(su_eff) << (DW - 1);
      for (int l = 0; l < 2; l++) begin
        rem[l]  <= '0;
        prod[l] <= '0;
        du[l]   <= '0;
      end
    end
    if (cmd.div_step) begin
      for (int l = 0; l < 2; l++) begin
        rem[l]  <= big_rem[l];
        prod[l] <= {prod[l][SPAN_W-2:0], 1'b0}
                   + (big_ge[l] ? SPAN_W'(su_eff) : SPAN_W'(0));
        dvd[l]  <= {dvd[l][SPAN_W-2:0], 1'b0};
      end
    end
    if (cmd.unit_step) begin
      for (int l = 0; l < 2; l++) begin
        if (unit_ge[l]) rem[l] <= rem[l] - dsr;
        // shift in the next quotient bit, drop the top one
        du[l] <= DW'({du[l], unit_ge[l]});
      end
      dsr <= dsr >> 1;
    end
    if (cmd.span) begin
      s_reg <= prod[0] + add_s;
      e_reg <= prod[1] + add_e;
    end
    if (cmd.emit_child) begin
      kind           <= wr ? KIND_DEV_WRITE : KIND_DEV_READ;
      device_index   <= child_dev;
      device_address <= s_reg[ADDR_W-1:0];
      length_bytes   <= diff[LEN_W-1:0];
      child_count    <= '0;
      last           <= 1'b0;
    end else if (cmd.emit_parent) begin
      kind           <= wr ? KIND_WRITE_PARENT : KIND_READ_PARENT;
      device_index   <= base;
      device_address <= '0;
      length_bytes   <= '0;
      child_count    <= count;
      last           <= 1'b1;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      toggle    <= 1'b0;
      count     <= '0;
      idx       <= '0;
    end else begin
      if (cmd.emit_child || cmd.emit_parent) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      if (cmd.load) count <= '0;
      else if (cmd.emit_child) count <= count + 1'b1;

      if (cmd.emit_child && !wr) toggle <= !toggle;

      if (cmd.setup) idx <= '0;
      else if (cmd.idx_next) idx <= idx + 1'b1;
    end
  end

endmodule

// File: sv/raid01_stripe_decomposer.sv
// Top level of the RAID 0+1 stripe decomposer.
//
// Splits one volume request (byte address, byte count, read/write) across
// devices_per_side striped data devices mirrored onto as many more. Each data
// device with a non-empty share gets a device request carrying its local start
// address and length; a write goes to the data device and then to its mirror,
// a read goes to one copy chosen by a toggle that flips after every device read.
// Each run closes with a parent record (last=1) holding the child count.
// Timing: a request is accepted only while the block is idle. After accept,
// a setup state forms the stripe size, then a bit-serial restoring divider
// works on the first and last byte addresses in two parallel lanes, and a
// step divider splits the stripe remainders into device and offset. Each data
// device then passes a span state and an emit state (plus a mirror state when
// a write emits its mirror copy), and the parent record closes the run; output
// stalls hold the emit, mirror and parent states. A request of zero bytes
// skips straight to the parent record. Results leave through an output
// register; the block returns to idle once its parent record is registered,
// so a stall of that record does not hold the next accept, but earlier ones do.
// Configuration registers (APB, byte addresses 0, 4, 8): devices_per_side,
// stripe_unit_bytes, device_base; out-of-range values are clamped per request.
module raid01_stripe_decomposer #(
  parameter int MAX_DEVICES_PER_SIDE = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsd_pkg::APB_AW-1:0]  paddr,
  input  logic [rsd_pkg::APB_DW-1:0]  pwdata,
  output logic [rsd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // volume request in
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rsd_pkg::ADDR_W-1:0]  volume_address,
  input  logic [rsd_pkg::LEN_W-1:0]   request_bytes,
  input  logic                        is_write,
  // device requests and parent record out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  kind,
  output logic [rsd_pkg::DEV_W-1:0]   device_index,
  output logic [rsd_pkg::ADDR_W-1:0]  device_address,
  output logic [rsd_pkg::LEN_W-1:0]   length_bytes,
  output logic [rsd_pkg::CNT_W-1:0]   child_count,
  output logic                        last
);
  import rsd_pkg::*;

  logic [CFG_N_W-1:0] cfg_devices;
  logic [SU_W-1:0]    cfg_stripe_unit;
  logic [DEV_W-1:0]   cfg_device_base;
  cmd_t               cmd;
  status_t            status;

  // register file: raw values, clamped by the datapath at accept
  rsd_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .cfg_devices     (cfg_devices),
    .cfg_stripe_unit (cfg_stripe_unit),
    .cfg_device_base (cfg_device_base)
  );

  // sequencer: divide, walk the devices, close with the parent record
  rsd_ctrl #(
    .MAX_DEVICES_PER_SIDE (MAX_DEVICES_PER_SIDE)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: divider lanes, span edges, read-copy toggle, output register
  rsd_dpath #(
    .MAX_DEVICES_PER_SIDE (MAX_DEVICES_PER_SIDE)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .volume_address  (volume_address),
    .request_bytes   (request_bytes),
    .is_write        (is_write),
    .cfg_devices     (cfg_devices),
    .cfg_stripe_unit (cfg_stripe_unit),
    .cfg_device_base (cfg_device_base),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .kind            (kind),
    .device_index    (device_index),
    .device_address  (device_address),
    .length_bytes    (length_bytes),
    .child_count     (child_count),
    .last            (last)
  );

endmodule

// File: sv/rsd_checker.sv
// Port-level checks of the stripe decomposer, bound to the top level.
module rsd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [1:0]                  kind,
  input logic [rsd_pkg::DEV_W-1:0]   device_index,
  input logic [rsd_pkg::ADDR_W-1:0]  device_address,
  input logic [rsd_pkg::LEN_W-1:0]   length_bytes,
  input logic [rsd_pkg::CNT_W-1:0]   child_count,
  input logic                        last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(device_index)
      && $stable(device_address) && $stable(length_bytes)
      && $stable(child_count) && $stable(last))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new request taken right after accept");

  // parent record shape
  a_parent: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> kind[1] && device_address == '0 && length_bytes == '0)
    else $error("malformed parent record");

  // device request shape
  a_child: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !kind[1] && child_count == '0 && length_bytes != '0)
    else $error("malformed device request");

endmodule

bind raid01_stripe_decomposer rsd_checker u_rsd_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .kind           (kind),
  .device_index   (device_index),
  .device_address (device_address),
  .length_bytes   (length_bytes),
  .child_count    (child_count),
  .last           (last)
);

// File: test/raid01_stripe_decomposer_test.sv
// Self-checking testbench for the RAID 0+1 stripe decomposer.
module raid01_stripe_decomposer_test;
  import rsd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_DEV      = 16;
  // Register slot past the last real register; writes to it must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // One device request or parent record, field for field as the block emits it.
  typedef struct packed {
    logic [1:0]        kind;
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [CNT_W-1:0]  count;
    logic              last;
  } dev_request_t;

  // Predicts the device requests of each volume request and checks the
  // block's output against them in order.
  class decomposer_scoreboard;
    logic [CFG_N_W-1:0] ndev_cfg;
    logic [SU_W-1:0]    unit_cfg;
    logic [DEV_W-1:0]   base_cfg;
    bit                 read_copy;
    dev_request_t       outstanding[$];
    int unsigned        mismatches;

    function new();
      ndev_cfg   = CFG_N_W'(2);
      unit_cfg   = SU_W'(4096);
      base_cfg   = '0;
      read_copy  = 1'b0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_DEVICES:     ndev_cfg = value[CFG_N_W-1:0];
        REG_STRIPE_UNIT: unit_cfg = value[SU_W-1:0];
        REG_DEVICE_BASE: base_cfg = value[DEV_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamped device count and stripe unit, as the block uses them per request.
    function bit [63:0] dev_count();
      if (ndev_cfg == 0) return 64'd1;
      if (ndev_cfg > MAX_DEV) return 64'(MAX_DEV);
      return 64'(ndev_cfg);
    endfunction

    function bit [63:0] unit_size();
      if (unit_cfg == 0) return 64'd1;
      if (unit_cfg > SU_MAX) return 64'(SU_MAX);
      return 64'(unit_cfg);
    endfunction

    function void queue_result(logic [1:0] kind, bit [63:0] dev, bit [63:0] addr,
                               bit [63:0] len, bit [63:0] count, logic last);
      dev_request_t r;
      r.kind  = kind;
      r.dev   = dev[DEV_W-1:0];
      r.addr  = addr[ADDR_W-1:0];
      r.len   = len[LEN_W-1:0];
      r.count = count[CNT_W-1:0];
      r.last  = last;
      outstanding = {outstanding, r};
    endfunction

    function void note_request(logic [ADDR_W-1:0] vaddr, logic [LEN_W-1:0] nbytes,
                               logic wr);
      bit [63:0] n, su, stripe, lastb, first_stripe, last_stripe, first_du, last_du;
      bit [63:0] s, e, children;
      n = dev_count();
      su = unit_size();
      children = 0;
      if (nbytes != 0) begin
        stripe       = n * su;
        lastb        = 64'(vaddr) + 64'(nbytes) - 1;
        first_stripe = 64'(vaddr) / stripe;
        last_stripe  = lastb / stripe;
        first_du     = (64'(vaddr) % stripe) / su;
        last_du      = (lastb % stripe) / su;
        for (bit [63:0] i = 0; i < n; i++) begin
          s = first_stripe * su;
          e = last_stripe * su;
          if (i < first_du) s += su;
          else if (i == first_du) s += 64'(vaddr) % su;
          if (i < last_du) e += su;
          else if (i == last_du) e += (lastb % su) + 1;
          if (s < e) begin
            if (wr) begin
              // data device first, then its mirror
              queue_result(KIND_DEV_WRITE, base_cfg + i, s, e - s, 0, 1'b0);
              queue_result(KIND_DEV_WRITE, base_cfg + i + n, s, e - s, 0, 1'b0);
              children += 2;
            end else begin
              queue_result(KIND_DEV_READ, base_cfg + i + (read_copy ? n : 0),
                           s, e - s, 0, 1'b0);
              read_copy ^= 1'b1;
              children += 1;
            end
          end
        end
      end
      queue_result(wr ? KIND_WRITE_PARENT : KIND_READ_PARENT, base_cfg, 0, 0,
                   children, 1'b1);
    endfunction

    function int pending();
      return outstanding.size();
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_result(dev_request_t got);
      dev_request_t want;
      if (outstanding.size() == 0) begin
        report($sformatf("unexpected result kind %0d dev %0d addr %0h len %0h",
                         got.kind, got.dev, got.addr, got.len));
        return;
      end
      want = outstanding.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.dev !== want.dev)
        report($sformatf("device_index %0d, want %0d", got.dev, want.dev));
      if (got.addr !== want.addr)
        report($sformatf("device_address %0h, want %0h", got.addr, want.addr));
      if (got.len !== want.len)
        report($sformatf("length_bytes %0h, want %0h", got.len, want.len));
      if (got.count !== want.count)
        report($sformatf("child_count %0d, want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid, in_stall;
  logic [ADDR_W-1:0]   volume_address;
  logic [LEN_W-1:0]    request_bytes;
  logic                is_write;
  logic                out_valid, out_stall;
  logic [1:0]          kind;
  logic [DEV_W-1:0]    device_index;
  logic [ADDR_W-1:0]   device_address;
  logic [LEN_W-1:0]    length_bytes;
  logic [CNT_W-1:0]    child_count;
  logic                last;

  decomposer_scoreboard sb;

  // Idling controls: steady sides never wait; a long hold parks the receiver.
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_long_hold = 0;

  raid01_stripe_decomposer u_top (.*);

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Hard limit on the run, well above the slowest legal run.
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("[raid01_stripe_decomposer] ERROR");
    $finish;
  end

  // Result side: draw a stall per result, then wait for a result and check it.
  initial begin : result_sink
    int hold;
    dev_request_t got;
    wait (rst === 1'b0);
    forever begin
      if (rx_long_hold != 0) begin
        hold = rx_long_hold;
        rx_long_hold = 0;
      end else begin
        hold = rx_steady ? 0 : $urandom_range(0, 19);
      end
      if (hold > 0) begin
        // hold off the block while counting cycles here
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got = {kind, device_index, device_address, length_bytes, child_count, last};
      sb.check_result(got);
    end
  end

  // Write one register: setup phase, access phase, then an idle phase so the
  // next write never lowers and raises psel in the same step.
  task automatic apb_write(logic [1:0] index, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(index, value);
    @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] ndev, logic [31:0] unit, logic [31:0] base);
    apb_write(REG_DEVICES, ndev);
    apb_write(REG_STRIPE_UNIT, unit);
    apb_write(REG_DEVICE_BASE, base);
  endtask

  // Offer one volume request after a drawn gap and hold it until accepted.
  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send_request(logic [ADDR_W-1:0] vaddr, logic [LEN_W-1:0] nbytes,
                              logic wr);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    volume_address <= vaddr;
    request_bytes  <= nbytes;
    is_write       <= wr;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_request(vaddr, nbytes, wr);
  endtask

  // Drop the request line and wait until every predicted result has arrived.
  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Random phase: fresh random configuration, then a mix of requests that
  // stay near stripe boundaries, span many stripes, or hit the address top.
  task automatic random_phase(int items);
    bit [63:0] stripe;
    logic [31:0] ndev, unit;
    logic [ADDR_W-1:0] vaddr;
    logic [LEN_W-1:0] nbytes;
    ndev = $urandom;
    if ($urandom_range(0, 3) != 0)
      ndev[CFG_N_W-1:0] = CFG_N_W'($urandom_range(1, MAX_DEV));
    unit = $urandom;
    case ($urandom_range(0, 3))
      0: unit[SU_W-1:0] = SU_W'($urandom_range(1, 16));
      1: unit[SU_W-1:0] = 25'd1 << $urandom_range(0, 24);
      2: unit[SU_W-1:0] = SU_W'($urandom_range(500, 70000));
      default: ;
    endcase
    write_config(ndev, unit, $urandom);
    stripe = sb.dev_count() * sb.unit_size();
    repeat (items) begin
      case ($urandom_range(0, 3))
        0, 1: vaddr = ADDR_W'($urandom_range(0, 32'(4 * stripe)));
        2:    vaddr = ADDR_W'({$urandom, $urandom});
        default: vaddr = {ADDR_W{1'b1}} - ADDR_W'($urandom_range(0, 32'(stripe)));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: nbytes = $urandom_range(1, 32'(3 * stripe));
        6, 7: nbytes = $urandom_range(1, 64);
        8:    nbytes = $urandom;
        default: nbytes = $urandom_range(0, 1) ? '0 : '1;
      endcase
      send_request(vaddr, nbytes, 1'($urandom_range(0, 1)));
    end
    drain(4);
  endtask

  initial begin : stimulus
    sb = new();
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    volume_address = '0;
    request_bytes  = '0;
    is_write       = 1'b0;
    out_stall      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: two devices, 4 KiB units, base 0.
    send_request('0, 32'd1, 1'b0);
    send_request('0, 32'd1, 1'b1);
    // empty requests: parent record only, toggle untouched
    send_request('0, '0, 1'b0);
    send_request(48'd5000, '0, 1'b1);
    send_request(48'd4095, 32'd2, 1'b0);
    send_request(48'd8192, 32'd8192, 1'b1);
    send_request(48'd100, 32'd20000, 1'b0);
    // top of the address space with the longest request: span runs past 48 bits
    send_request('1, '1, 1'b0);
    send_request('1, '1, 1'b1);
    drain(4);

    // Widest array, one-byte units, base that wraps the device number.
    write_config(32'd16, 32'd1, 32'd250);
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_request(48'd3, 32'd40, 1'b1);
    send_request(48'd3, 32'd40, 1'b0);
    send_request('0, 32'd1, 1'b0);
    send_request('1, 32'd1, 1'b1);
    drain(4);

    // Zero device count and zero unit act as one.
    write_config(32'd0, 32'd0, 32'd0);
    send_request(48'd7, 32'd3, 1'b0);
    send_request('0, '1, 1'b1);
    drain(4);

    // Oversized device count and unit clamp to their maxima.
    write_config(32'd31, 32'h01FF_FFFF, 32'd223);
    send_request('0, '1, 1'b1);
    send_request('1, '1, 1'b0);
    send_request(48'd16777215, 32'd2, 1'b0);
    drain(4);

    // Single device with the largest legal unit, highest base.
    write_config(32'd1, 32'd16777216, 32'd255);
    send_request(48'd16777215, 32'd2, 1'b1);
    send_request('0, 32'd1, 1'b0);
    drain(4);

    random_phase(16);

    // Back-to-back stretch with no idling on either side.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_phase(16);

    // Park the receiver for a long stretch while requests keep coming, so
    // the output fills and the block stalls its input.
    rx_steady = 1'b0;
    rx_long_hold = 300;
    random_phase(16);
    tx_steady = 1'b0;

    random_phase(16);
    random_phase(16);

    // Wait out any stray result after the last expected one.
    drain(150);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.mismatches == 0) begin
      $display("[raid01_stripe_decomposer] OK");
    end else begin
      $display("[raid01_stripe_decomposer] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rsd_pkg.sv
sv/rsd_regs.sv
sv/rsd_ctrl.sv
sv/rsd_dpath.sv
sv/raid01_stripe_decomposer.sv
sv/rsd_checker.sv
test/raid01_stripe_decomposer_test.sv
